// ===== design/bpc_pkg.sv =====
// Package for the barometric compensation core: field widths, register
// indexes and the compensation constants. No dependencies.
package bpc_pkg;

	localparam int RAW_W   = 24;
	localparam int COEF_W  = 16;
	localparam int TEMP_W  = 16;
	localparam int PRES_W  = 19;
	localparam int CFG_A_W = 3;

	localparam int DT_W    = 25;
	localparam int MUL1_W  = 42;
	localparam int SQ_W    = 50;
	localparam int TC_W    = 19;
	localparam int OFF_W   = 42;
	localparam int CORR_W  = 41;
	localparam int SQT_W   = 36;
	localparam int SENS_W  = 43;
	localparam int SPLIT_W = 22;
	localparam int PP_W    = 46;
	localparam int PROD_W  = 68;
	localparam int Q1_W    = 47;
	localparam int V_W     = 48;
	localparam int PQ_W    = 33;

	localparam int TEMP_KNEE = 2000;
	localparam int TEMP_VLOW = -1500;
	localparam int OFF2_TX_K  = 61;
	localparam int SENS2_TX_K = 29;
	localparam int OFF2_TY_K  = 17;
	localparam int SENS2_TY_K = 9;

	localparam int TEMP_MIN = -32768;
	localparam int TEMP_MAX = 32767;
	localparam int PRES_MIN = -262144;
	localparam int PRES_MAX = 262143;

	typedef enum logic [CFG_A_W-1:0] {
		CFG_SENS         = 3'd0,
		CFG_OFFSET       = 3'd1,
		CFG_SENS_TEMPCO  = 3'd2,
		CFG_OFFSET_TEMPCO = 3'd3,
		CFG_REF_TEMP     = 3'd4,
		CFG_TEMP_SLOPE   = 3'd5,
		CFG_COEFS_OK     = 3'd6
	} cfg_reg_t;

endpackage

// ===== design/bpc_if.sv =====
// Valid/ready channel interfaces for the raw reading pair and the result.
// Depends on bpc_pkg.
interface bpc_sample_if;
	import bpc_pkg::*;
	logic              valid;
	logic              ready;
	logic [RAW_W-1:0]  pressure_raw;
	logic [RAW_W-1:0]  temperature_raw;
	modport source (output valid, output pressure_raw, output temperature_raw, input ready);
	modport sink (input valid, input pressure_raw, input temperature_raw, output ready);
endinterface

interface bpc_result_if;
	import bpc_pkg::*;
	logic                     valid;
	logic                     ready;
	logic                     compensated_ok;
	logic signed [TEMP_W-1:0] temperature_centi;
	logic signed [PRES_W-1:0] pressure_centi_mbar;
	modport source (output valid, output compensated_ok, output temperature_centi,
		output pressure_centi_mbar, input ready);
	modport sink (input valid, input compensated_ok, input temperature_centi,
		input pressure_centi_mbar, output ready);
endinterface

// ===== design/bpc_wide_mul.sv =====
// Two-stage unsigned 24 x signed 43 bit multiplier built from two registered partial
// products and a registered sum. Depends on bpc_pkg.
module bpc_wide_mul (
	input  logic                               clk,
	input  logic                               en,
	input  logic [bpc_pkg::RAW_W-1:0]          a,
	input  logic signed [bpc_pkg::SENS_W-1:0]  b,
	output logic signed [bpc_pkg::PROD_W-1:0]  p
);
	import bpc_pkg::*;

	logic [PP_W-1:0]        lo_pp_s1;
	logic signed [PP_W-1:0] hi_pp_s1;
	logic signed [PROD_W-1:0] p_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			lo_pp_s1 <= a * b[SPLIT_W-1:0];
			hi_pp_s1 <= $signed({1'b0, a}) * $signed(b[SENS_W-1:SPLIT_W]);
			p_s2     <= $signed({hi_pp_s1, {SPLIT_W{1'b0}}})
				+ $signed({{SPLIT_W{1'b0}}, lo_pp_s1});
		end
	end

	assign p = p_s2;

endmodule

// ===== design/baro_temp_pressure_compensation_core.sv =====
// Second-order barometric temperature and pressure compensation core.
// Pipeline: 11 register stages, from request acceptance to the result register.
// Throughput: one request per cycle; the whole pipeline holds while the
// result register is full and not taken.
// Reset: arst_n clears all valid bits and the coefficient registers.
// Depends on bpc_pkg, bpc_if and bpc_wide_mul.
module baro_temp_pressure_compensation_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [bpc_pkg::CFG_A_W-1:0]  cfg_index,
	input  logic [bpc_pkg::COEF_W-1:0]   cfg_wdata,
	bpc_sample_if.sink                   sample,
	bpc_result_if.source                 result
);
	import bpc_pkg::*;

	logic [COEF_W-1:0] coef_sens_q, coef_offset_q, coef_sens_tempco_q;
	logic [COEF_W-1:0] coef_offset_tempco_q, coef_ref_temp_q, coef_temp_slope_q;
	logic              coefs_ok_q;

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;

	logic ok_s1, ok_s2, ok_s3, ok_s4, ok_s5, ok_s6, ok_s7, ok_s8, ok_s9, ok_s10, ok_s11;
	logic [RAW_W-1:0] d1_s1, d1_s2, d1_s3, d1_s4, d1_s5, d1_s6;
	logic signed [DT_W-1:0]   dt_s1;
	logic signed [MUL1_W-1:0] dtc6_s2, c4dt_s2, c3dt_s2;
	logic signed [SQ_W-1:0]   dd_s2;
	logic signed [TC_W-1:0]   temp_s3;
	logic signed [OFF_W-1:0]  off_s3, off_s4, off_s5, sens_s3, sens_s4, sens_s5;
	logic [12:0]              t2_hi_s3;
	logic [16:0]              t2_lo_s3;
	logic                     low_s4, vlow_s4, low_s5;
	logic [SQT_W-1:0]         tx_s4, ty_s4;
	logic signed [TEMP_W-1:0] tout_s4, tout_s5, tout_s6, tout_s7, tout_s8, tout_s9;
	logic signed [TEMP_W-1:0] tout_s10, tout_s11;
	logic [CORR_W-1:0]        off2_s5, sens2_s5;
	logic signed [SENS_W-1:0] off_s6, off_s7, off_s8, off_s9, sens_s6;
	logic signed [Q1_W-1:0]   q1_s9;
	logic signed [V_W-1:0]    v_diff_s10;
	logic signed [PRES_W-1:0] pres_s11;

	// combinational stage logic
	logic signed [TC_W-1:0]   t_div, temp_w;
	logic signed [35:0]       off_div;
	logic signed [34:0]       sens_div;
	logic [50:0]              dd5;
	logic [49:0]              dd3;
	logic signed [19:0]       td, tv, tdiff;
	logic signed [39:0]       tx_full, ty_full;
	logic [16:0]              t2_w;
	logic signed [TEMP_W-1:0] tout_w;
	logic [CORR_W-1:0]        tx61, tx29, ty17, ty9, off2_w, sens2_w;
	logic signed [PROD_W-1:0] prod_w;
	logic signed [PQ_W-1:0]   p_div;
	logic signed [PRES_W-1:0] pres_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_sens_q          <= '0;
			coef_offset_q        <= '0;
			coef_sens_tempco_q   <= '0;
			coef_offset_tempco_q <= '0;
			coef_ref_temp_q      <= '0;
			coef_temp_slope_q    <= '0;
			coefs_ok_q           <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SENS:          coef_sens_q          <= cfg_wdata;
				CFG_OFFSET:        coef_offset_q        <= cfg_wdata;
				CFG_SENS_TEMPCO:   coef_sens_tempco_q   <= cfg_wdata;
				CFG_OFFSET_TEMPCO: coef_offset_tempco_q <= cfg_wdata;
				CFG_REF_TEMP:      coef_ref_temp_q      <= cfg_wdata;
				CFG_TEMP_SLOPE:    coef_temp_slope_q    <= cfg_wdata;
				CFG_COEFS_OK:      coefs_ok_q           <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign adv = !v_s11 || result.ready;
	assign sample.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6} <= '0;
			{v_s7, v_s8, v_s9, v_s10, v_s11} <= '0;
		end else if (adv) begin
			v_s1  <= sample.valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

	always_comb begin
		t_div = $signed(dtc6_s2[MUL1_W-1:23])
			+ $signed({{(TC_W-1){1'b0}}, dtc6_s2[MUL1_W-1] & (|dtc6_s2[22:0])});
		temp_w = t_div + TC_W'(TEMP_KNEE);
		off_div = $signed(c4dt_s2[MUL1_W-1:6])
			+ $signed({35'd0, c4dt_s2[MUL1_W-1] & (|c4dt_s2[5:0])});
		sens_div = $signed(c3dt_s2[MUL1_W-1:7])
			+ $signed({34'd0, c3dt_s2[MUL1_W-1] & (|c3dt_s2[6:0])});
		dd5 = {1'b0, dd_s2[47:0], 2'b00} + {3'b000, dd_s2[47:0]};
		dd3 = {1'b0, dd_s2[47:0], 1'b0} + {2'b00, dd_s2[47:0]};
	end

	always_comb begin
		td      = {temp_s3[TC_W-1], temp_s3} - 20'(TEMP_KNEE);
		tv      = {temp_s3[TC_W-1], temp_s3} - 20'(TEMP_VLOW);
		tx_full = td * td;
		ty_full = tv * tv;
		t2_w    = (temp_s3 < TC_W'(TEMP_KNEE)) ? t2_lo_s3 : {4'd0, t2_hi_s3};
		tdiff   = {temp_s3[TC_W-1], temp_s3} - $signed({3'b000, t2_w});
		if (tdiff < 20'(TEMP_MIN))
			tout_w = TEMP_W'(TEMP_MIN);
		else if (tdiff > 20'(TEMP_MAX))
			tout_w = TEMP_W'(TEMP_MAX);
		else
			tout_w = tdiff[TEMP_W-1:0];
	end

	always_comb begin
		tx61 = {5'd0, tx_s4} * CORR_W'(OFF2_TX_K);
		tx29 = {5'd0, tx_s4} * CORR_W'(SENS2_TX_K);
		ty17 = {5'd0, ty_s4} * CORR_W'(OFF2_TY_K);
		ty9  = {5'd0, ty_s4} * CORR_W'(SENS2_TY_K);
		off2_w  = '0;
		sens2_w = '0;
		if (low_s4) begin
			off2_w  = (tx61 >> 4) + (vlow_s4 ? ty17 : '0);
			sens2_w = (tx29 >> 4) + (vlow_s4 ? ty9 : '0);
		end
	end

	always_comb begin
		p_div = $signed(v_diff_s10[V_W-1:15])
			+ $signed({{(PQ_W-1){1'b0}}, v_diff_s10[V_W-1] & (|v_diff_s10[14:0])});
		if (p_div < PQ_W'(PRES_MIN))
			pres_w = PRES_W'(PRES_MIN);
		else if (p_div > PQ_W'(PRES_MAX))
			pres_w = PRES_W'(PRES_MAX);
		else
			pres_w = p_div[PRES_W-1:0];
	end

	bpc_wide_mul u_mul (
		.clk (clk),
		.en  (adv),
		.a   (d1_s6),
		.b   (sens_s6),
		.p   (prod_w)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s1 <= coefs_ok_q && (|sample.pressure_raw) && (|sample.temperature_raw);
			d1_s1 <= sample.pressure_raw;
			dt_s1 <= $signed({1'b0, sample.temperature_raw})
				- $signed({1'b0, coef_ref_temp_q, 8'd0});

			ok_s2   <= ok_s1;
			d1_s2   <= d1_s1;
			dtc6_s2 <= dt_s1 * $signed({1'b0, coef_temp_slope_q});
			c4dt_s2 <= dt_s1 * $signed({1'b0, coef_offset_tempco_q});
			c3dt_s2 <= dt_s1 * $signed({1'b0, coef_sens_tempco_q});
			dd_s2   <= dt_s1 * dt_s1;

			ok_s3    <= ok_s2;
			d1_s3    <= d1_s2;
			temp_s3  <= temp_w;
			off_s3   <= $signed({9'd0, coef_offset_q, 17'd0})
				+ {{(OFF_W-36){off_div[35]}}, off_div};
			sens_s3  <= $signed({10'd0, coef_sens_q, 16'd0})
				+ {{(OFF_W-35){sens_div[34]}}, sens_div};
			t2_hi_s3 <= dd5[50:38];
			t2_lo_s3 <= dd3[49:33];

			ok_s4   <= ok_s3;
			d1_s4   <= d1_s3;
			low_s4  <= temp_s3 < TC_W'(TEMP_KNEE);
			vlow_s4 <= temp_s3 < TC_W'(TEMP_VLOW);
			tx_s4   <= tx_full[SQT_W-1:0];
			ty_s4   <= ty_full[SQT_W-1:0];
			tout_s4 <= tout_w;
			off_s4  <= off_s3;
			sens_s4 <= sens_s3;

			ok_s5    <= ok_s4;
			d1_s5    <= d1_s4;
			low_s5   <= low_s4;
			off2_s5  <= off2_w;
			sens2_s5 <= sens2_w;
			tout_s5  <= tout_s4;
			off_s5   <= off_s4;
			sens_s5  <= sens_s4;

			ok_s6   <= ok_s5;
			d1_s6   <= d1_s5;
			tout_s6 <= tout_s5;
			off_s6  <= {off_s5[OFF_W-1], off_s5} - $signed({2'b00, off2_s5});
			sens_s6 <= {sens_s5[OFF_W-1], sens_s5} - $signed({2'b00, sens2_s5});

			ok_s7   <= ok_s6;
			tout_s7 <= tout_s6;
			off_s7  <= off_s6;

			ok_s8   <= ok_s7;
			tout_s8 <= tout_s7;
			off_s8  <= off_s7;

			ok_s9   <= ok_s8;
			tout_s9 <= tout_s8;
			off_s9  <= off_s8;
			q1_s9   <= $signed(prod_w[PROD_W-1:21])
				+ $signed({{(Q1_W-1){1'b0}}, prod_w[PROD_W-1] & (|prod_w[20:0])});

			ok_s10     <= ok_s9;
			tout_s10   <= tout_s9;
			v_diff_s10 <= {q1_s9[Q1_W-1], q1_s9}
				- {{(V_W-SENS_W){off_s9[SENS_W-1]}}, off_s9};

			ok_s11   <= ok_s10;
			tout_s11 <= ok_s10 ? tout_s10 : '0;
			pres_s11 <= ok_s10 ? pres_w : '0;
		end
	end

	assign result.valid               = v_s11;
	assign result.compensated_ok      = ok_s11;
	assign result.temperature_centi   = tout_s11;
	assign result.pressure_centi_mbar = pres_s11;

`ifndef SYNTH
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s11 && !ok_s11 |-> tout_s11 == '0 && pres_s11 == '0)
		else $error("failed result carries nonzero values");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v_s6) && $stable(v_s11))
		else $error("pipeline moved during a stall");

	a_adv: assert property (@(posedge clk) disable iff (!arst_n)
		adv && v_s5 |=> v_s6)
		else $error("request lost between stages");

	a_no_corr: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && !low_s5 |-> off2_s5 == '0 && sens2_s5 == '0)
		else $error("low temperature correction applied above the knee");
`endif

endmodule

// ===== dv/baro_temp_pressure_compensation_core_tb.sv =====
// Testbench for baro_temp_pressure_compensation_core: drives raw reading pairs and
// coefficient writes, predicts every compensated result and checks it in order.
// Depends on bpc_pkg, bpc_if and the core.
`timescale 1ns / 1ps

module baro_temp_pressure_compensation_core_tb;
	import bpc_pkg::*;

	localparam int     LATENCY      = 11;
	localparam int     CYCLE_LIMIT  = 400000;
	localparam int     RANDOM_PHASES = 10;
	localparam int     PHASE_ITEMS  = 50;
	localparam logic [CFG_A_W-1:0] CFG_UNUSED = 3'd7;
	localparam logic [COEF_W-1:0]  COEF_MAX   = 16'hFFFF;
	localparam logic [RAW_W-1:0]   RAW_MAX    = 24'hFFFFFF;

	localparam longint DIV_2_6  = 64'sd1 << 6;
	localparam longint DIV_2_7  = 64'sd1 << 7;
	localparam longint DIV_2_15 = 64'sd1 << 15;
	localparam longint DIV_2_16 = 64'sd1 << 16;
	localparam longint DIV_2_17 = 64'sd1 << 17;
	localparam longint DIV_2_21 = 64'sd1 << 21;
	localparam longint DIV_2_23 = 64'sd1 << 23;
	localparam longint DIV_2_33 = 64'sd1 << 33;
	localparam longint DIV_2_38 = 64'sd1 << 38;

	typedef struct packed {
		logic                     ok;
		logic signed [TEMP_W-1:0] temp_centi;
		logic signed [PRES_W-1:0] pres_centi;
	} comp_result_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CFG_A_W-1:0]  cfg_index;
	logic [COEF_W-1:0]   cfg_wdata;

	bpc_sample_if sample_ch();
	bpc_result_if result_ch();

	baro_temp_pressure_compensation_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.sample    (sample_ch),
		.result    (result_ch)
	);

	logic [COEF_W-1:0] c_sens, c_offset, c_sens_tc, c_offset_tc, c_ref_temp, c_temp_slope;
	logic              c_ok;

	comp_result_t pending_results_q[$];
	comp_result_t want;
	int           mismatch_count;
	int           cycle_count;
	int           ready_hold;
	bit           idle_gaps;

	function automatic comp_result_t compensate_reading(logic [RAW_W-1:0] p_raw,
			logic [RAW_W-1:0] t_raw);
		longint d1, d2, c1, c2, c3, c4, c5, c6;
		longint dt, temp, t2, off, sens, tx, ty, off2, sens2, pres;
		comp_result_t r;
		r = '0;
		if (!c_ok || p_raw == 0 || t_raw == 0)
			return r;
		d1 = p_raw;
		d2 = t_raw;
		c1 = c_sens;
		c2 = c_offset;
		c3 = c_sens_tc;
		c4 = c_offset_tc;
		c5 = c_ref_temp;
		c6 = c_temp_slope;
		dt = d2 - c5 * 256;
		temp = TEMP_KNEE + (dt * c6) / DIV_2_23;
		if (temp >= TEMP_KNEE)
			t2 = 5 * (dt * dt) / DIV_2_38;
		else
			t2 = 3 * (dt * dt) / DIV_2_33;
		off = c2 * DIV_2_17 + (c4 * dt) / DIV_2_6;
		sens = c1 * DIV_2_16 + (c3 * dt) / DIV_2_7;
		if (temp < TEMP_KNEE) begin
			tx = (temp - TEMP_KNEE) * (temp - TEMP_KNEE);
			off2 = OFF2_TX_K * tx / 16;
			sens2 = SENS2_TX_K * tx / 16;
			if (temp < TEMP_VLOW) begin
				ty = (temp - TEMP_VLOW) * (temp - TEMP_VLOW);
				off2 += OFF2_TY_K * ty;
				sens2 += SENS2_TY_K * ty;
			end
			off -= off2;
			sens -= sens2;
		end
		pres = (d1 * sens / DIV_2_21 - off) / DIV_2_15;
		temp = temp - t2;
		if (temp < TEMP_MIN) temp = TEMP_MIN;
		if (temp > TEMP_MAX) temp = TEMP_MAX;
		if (pres < PRES_MIN) pres = PRES_MIN;
		if (pres > PRES_MAX) pres = PRES_MAX;
		r.ok = 1'b1;
		r.temp_centi = temp[TEMP_W-1:0];
		r.pres_centi = pres[PRES_W-1:0];
		return r;
	endfunction

	function automatic logic [COEF_W-1:0] rand_coef();
		int sel;
		sel = $urandom_range(7);
		if (sel == 0)
			return '0;
		if (sel == 1)
			return COEF_MAX;
		return COEF_W'($urandom);
	endfunction

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Receiver: a counted hold-off when one is requested, else random stalls while idle gaps are on, else always ready.
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (ready_hold > 0) begin
				result_ch.ready <= 1'b0;
				ready_hold--;
			end else if (idle_gaps) begin
				result_ch.ready <= ($urandom_range(99) >= 24);
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_results_q.size() == 0) begin
				$error("result with no request pending: ok %0b temp %0d pres %0d",
					result_ch.compensated_ok, result_ch.temperature_centi,
					result_ch.pressure_centi_mbar);
				mismatch_count++;
			end else begin
				want = pending_results_q.pop_front();
				if (result_ch.compensated_ok !== want.ok) begin
					$error("compensated_ok: expected %0b, got %0b", want.ok,
						result_ch.compensated_ok);
					mismatch_count++;
				end
				if (result_ch.temperature_centi !== want.temp_centi) begin
					$error("temperature_centi: expected %0d, got %0d", want.temp_centi,
						result_ch.temperature_centi);
					mismatch_count++;
				end
				if (result_ch.pressure_centi_mbar !== want.pres_centi) begin
					$error("pressure_centi_mbar: expected %0d, got %0d", want.pres_centi,
						result_ch.pressure_centi_mbar);
					mismatch_count++;
				end
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_pair(input logic [RAW_W-1:0] p, input logic [RAW_W-1:0] t);
		while (idle_gaps && $urandom_range(99) < 24) begin
			sample_ch.valid <= 1'b0;
			@(negedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.pressure_raw <= p;
		sample_ch.temperature_raw <= t;
		do @(posedge clk); while (!sample_ch.ready);
		pending_results_q.push_back(compensate_reading(p, t));
		@(negedge clk);
	endtask

	task automatic wait_for_drain();
		sample_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending_results_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [COEF_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		unique case (idx)
			CFG_SENS:          c_sens = val;
			CFG_OFFSET:        c_offset = val;
			CFG_SENS_TEMPCO:   c_sens_tc = val;
			CFG_OFFSET_TEMPCO: c_offset_tc = val;
			CFG_REF_TEMP:      c_ref_temp = val;
			CFG_TEMP_SLOPE:    c_temp_slope = val;
			CFG_COEFS_OK:      c_ok = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic load_coefs(input logic [COEF_W-1:0] s, input logic [COEF_W-1:0] o,
			input logic [COEF_W-1:0] sc, input logic [COEF_W-1:0] oc,
			input logic [COEF_W-1:0] rt, input logic [COEF_W-1:0] ts, input bit ok);
		logic [COEF_W-1:0] ok_word;
		ok_word = COEF_W'($urandom);
		ok_word[0] = ok;
		write_reg(CFG_SENS, s);
		write_reg(CFG_OFFSET, o);
		write_reg(CFG_SENS_TEMPCO, sc);
		write_reg(CFG_OFFSET_TEMPCO, oc);
		write_reg(CFG_REF_TEMP, rt);
		write_reg(CFG_TEMP_SLOPE, ts);
		write_reg(CFG_COEFS_OK, ok_word);
	endtask

	task automatic test_reference_points();
		load_coefs(16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165, 1'b1);
		send_pair(24'd6465444, 24'd8077636);
		send_pair(24'd6465444, 24'd7481918);
		send_pair(24'd6465444, 24'd7000000);
		send_pair(24'd6465444, 24'd1);
		send_pair(24'd6465444, RAW_MAX);
		send_pair(24'd1, 24'd8077636);
		send_pair(RAW_MAX, 24'd8077636);
		send_pair(RAW_MAX, 24'd1);
		send_pair(24'd1, RAW_MAX);
		send_pair(24'd0, 24'd8077636);
		send_pair(24'd6465444, 24'd0);
		send_pair(24'd0, 24'd0);
		wait_for_drain();
	endtask

	task automatic test_coef_extremes();
		load_coefs('0, '0, '0, '0, '0, '0, 1'b1);
		send_pair(RAW_MAX, RAW_MAX);
		send_pair(24'd1, 24'd1);
		send_pair(24'h800000, 24'h000100);
		wait_for_drain();
		load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, 1'b1);
		send_pair(RAW_MAX, RAW_MAX);
		send_pair(24'd1, 24'd1);
		send_pair(RAW_MAX, 24'd1);
		send_pair(24'd1, RAW_MAX);
		wait_for_drain();
		load_coefs(COEF_MAX, '0, '0, '0, '0, COEF_MAX, 1'b1);
		send_pair(RAW_MAX, RAW_MAX);
		send_pair(24'd1, 24'd1);
		wait_for_drain();
	endtask

	task automatic test_invalid_coefs();
		write_reg(CFG_COEFS_OK, 16'hFFFE);
		send_pair(24'd6465444, 24'd8077636);
		send_pair(RAW_MAX, RAW_MAX);
		wait_for_drain();
		// unmapped index: must leave every coefficient as it is
		write_reg(CFG_UNUSED, COEF_W'($urandom));
		write_reg(CFG_COEFS_OK, 16'h0001);
		write_reg(CFG_UNUSED, COEF_W'($urandom));
		send_pair(24'd6465444, 24'd8077636);
		wait_for_drain();
	endtask

	task automatic test_backpressure();
		idle_gaps = 1'b0;
		@(posedge clk);
		ready_hold = 80;
		@(negedge clk);
		repeat (40)
			send_pair(RAW_W'($urandom), RAW_W'($urandom));
		wait_for_drain();
		idle_gaps = 1'b1;
	endtask

	task automatic test_random();
		logic [RAW_W-1:0] p, t;
		int               near_t, sel;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			load_coefs(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
				rand_coef(), $urandom_range(9) != 0);
			idle_gaps = (ph != 4);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				p = RAW_W'($urandom);
				if ($urandom_range(99) < 4)
					p = '0;
				sel = $urandom_range(99);
				if (sel < 4) begin
					t = '0;
				end else if (sel < 50) begin
					t = RAW_W'($urandom);
				end else begin
					// land near the reference temperature to straddle the knee
					near_t = int'(c_ref_temp) * 256 + int'($urandom_range(1 << 21)) - (1 << 20);
					if (near_t < 1) near_t = 1;
					if (near_t > int'(RAW_MAX)) near_t = int'(RAW_MAX);
					t = near_t[RAW_W-1:0];
				end
				send_pair(p, t);
				if (i == PHASE_ITEMS / 2 && ph == 6)
					wait_for_drain();
			end
			wait_for_drain();
		end
		idle_gaps = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_SENS;
		cfg_wdata = '0;
		sample_ch.valid = 1'b0;
		sample_ch.pressure_raw = '0;
		sample_ch.temperature_raw = '0;
		c_sens = '0;
		c_offset = '0;
		c_sens_tc = '0;
		c_offset_tc = '0;
		c_ref_temp = '0;
		c_temp_slope = '0;
		c_ok = 1'b0;
		mismatch_count = 0;
		cycle_count = 0;
		ready_hold = 0;
		idle_gaps = 1'b1;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reference_points();
		test_coef_extremes();
		test_invalid_coefs();
		test_backpressure();
		test_random();

		wait_for_drain();
		repeat (2 * LATENCY) @(posedge clk);
		if (mismatch_count == 0 && pending_results_q.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/bpc_pkg.sv
design/bpc_if.sv
design/bpc_wide_mul.sv
design/baro_temp_pressure_compensation_core.sv
dv/baro_temp_pressure_compensation_core_tb.sv
